[src/rvse_pkg.sv]
package rvse_pkg;

	typedef logic [4:0] op_t;

	localparam op_t OP_PUSH   = 5'd0;
	localparam op_t OP_ADD    = 5'd1;
	localparam op_t OP_SUB    = 5'd2;
	localparam op_t OP_MUL    = 5'd3;
	localparam op_t OP_DIV    = 5'd4;
	localparam op_t OP_INTPOW = 5'd5;
	localparam op_t OP_ADD2   = 5'd6;
	localparam op_t OP_ADD3   = 5'd7;
	localparam op_t OP_SUB2   = 5'd8;
	localparam op_t OP_SUB3   = 5'd9;
	localparam op_t OP_DOT2   = 5'd10;
	localparam op_t OP_DOT3   = 5'd11;
	localparam op_t OP_SCALE2 = 5'd12;
	localparam op_t OP_SCALE3 = 5'd13;
	localparam op_t OP_CROSS3 = 5'd14;
	localparam op_t OP_EQUALS = 5'd15;
	localparam op_t OP_END    = 5'd16;

	typedef logic [1:0] stat_t;

	localparam stat_t STAT_OK   = 2'd0;
	localparam stat_t STAT_OVF  = 2'd1;
	localparam stat_t STAT_UNF  = 2'd2;
	localparam stat_t STAT_DIVZ = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_EXEC,
		ST_MUL,
		ST_ADD,
		ST_RND,
		ST_DIV,
		ST_WB,
		ST_EMIT
	} state_t;

	// stack entries an operation consumes
	function automatic logic [2:0] need_of(op_t op);
		logic [2:0] n;
		case (op)
			OP_INTPOW: n = 3'd1;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: n = 3'd2;
			OP_SCALE2: n = 3'd3;
			OP_ADD2, OP_SUB2, OP_DOT2, OP_SCALE3: n = 3'd4;
			OP_ADD3, OP_SUB3, OP_DOT3, OP_CROSS3: n = 3'd6;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// entries an operation leaves in place of its operands
	function automatic logic [1:0] res_of(op_t op);
		logic [1:0] m;
		case (op)
			OP_ADD2, OP_SUB2, OP_SCALE2: m = 2'd2;
			OP_ADD3, OP_SUB3, OP_SCALE3, OP_CROSS3: m = 2'd3;
			default: m = 2'd1;
		endcase
		return m;
	endfunction

	// products summed per result
	function automatic logic [1:0] terms_of(op_t op);
		logic [1:0] t;
		case (op)
			OP_DOT2, OP_CROSS3: t = 2'd2;
			OP_DOT3: t = 2'd3;
			default: t = 2'd1;
		endcase
		return t;
	endfunction

	function automatic logic signed [31:0] sat66(logic signed [65:0] v);
		logic signed [31:0] r;
		if ((&v[65:31]) || !(|v[65:31]))
			r = v[31:0];
		else
			r = v[65] ? Q_MIN : Q_MAX;
		return r;
	endfunction

	function automatic logic signed [31:0] sat_addsub(logic signed [31:0] a,
			logic signed [31:0] b, logic sub);
		logic signed [32:0] s;
		s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
		return (s[32] != s[31]) ? (s[32] ? Q_MIN : Q_MAX) : s[31:0];
	endfunction

endpackage

[src/rvse_ram.sv]
module rvse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[src/rvse_div.sv]
module rvse_div #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int QW = 32 + FRACTION_BITS;
	localparam int KW = $clog2(QW + 1);

	logic          busy_q, done_q, neg_q;
	logic [KW-1:0] cnt_q;
	logic [32:0]   rem_q;
	logic [31:0]   dmag_q;
	logic [QW-1:0] q_q;

	logic [32:0]   rem_sh, rem_n;
	logic          ge;
	logic [31:0]   nmag, dmag;

	always_comb begin
		nmag = num[31] ? 32'(-num) : 32'(num);
		dmag = den[31] ? 32'(-den) : 32'(den);
		rem_sh = {rem_q[31:0], q_q[QW-1]};
		ge = rem_sh >= {1'b0, dmag_q};
		rem_n = ge ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
	end

	// restoring divide on magnitudes, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= KW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31] ^ den[31];
			rem_q <= '0;
			dmag_q <= dmag;
			q_q <= {nmag, {FRACTION_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= rem_n;
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (!neg_q)
			quo = (|q_q[QW-1:31]) ? rvse_pkg::Q_MAX : q_q[31:0];
		else if ((|q_q[QW-1:32]) || (q_q[31] && (|q_q[30:0])))
			quo = rvse_pkg::Q_MIN;
		else
			quo = 32'(-q_q[31:0]);
	end

	assign done = done_q;

endmodule

[src/rpn_vector_stack_evaluator_unit.sv]
// Push: accept state only. Other tokens: accept, a read state per stack entry below
// the top plus a last one, compute, then write-back (entered even with no extra result).
// Products: multiply and add states per term, a rounding state per result; intpow:
// multiply, add and rounding per exponent step; a nonzero divide waits for the divider.
// Equals/end emit one word per cycle when the output is free.
// arst_n clears stack count, top entry, error status and the output valid flag.
module rpn_vector_stack_evaluator_unit #(
	parameter int STACK_DEPTH   = 512,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // push_value[31:0], power_exponent[46:32], emit_count[48:47]
	input  logic [4:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // result_value
	output logic        m_tlast,
	output logic [1:0]  m_tuser   // status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;
	localparam logic signed [65:0] HALF = 66'sd1 <<< (FRACTION_BITS - 1);

	rvse_pkg::state_t state_q, state_d;

	logic [CW-1:0]      cnt_q, nc_q;
	logic signed [31:0] top_q, pw_q;
	rvse_pkg::stat_t    err_q;
	rvse_pkg::op_t      op_q;
	logic [14:0]        pexp_q, pe_q;
	logic signed [31:0] a_q [6];
	logic signed [31:0] r_q [3];
	logic [1:0]         m_q, t_q, j_q, wb_q, em_q, nem_q;
	logic [2:0]         nrd_q, rd_q, rd_dep_s1;
	logic               rd_pend_s1, eq_ok_q;
	logic signed [65:0] acc_q;
	logic signed [63:0] prod_s1;
	logic               out_valid_q, out_last_q;
	logic [31:0]        out_data_q;
	rvse_pkg::stat_t    out_stat_q;

	// input fields
	rvse_pkg::op_t      in_op;
	logic signed [31:0] in_val;
	logic [14:0]        in_exp;
	logic [1:0]         in_cnt, end_n;

	logic               accept, uflow, go_work;
	logic [2:0]         need, nrd_d;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;

	logic               div_start, div_done, emit_load;
	logic signed [31:0] div_quo, mx, my, rnd, emit_val;
	logic               mneg;
	logic signed [63:0] mprod;

	assign in_op  = s_tuser;
	assign in_val = s_tdata[31:0];
	assign in_exp = s_tdata[46:32];
	assign in_cnt = s_tdata[48:47];
	assign end_n  = (in_cnt == 2'd0) ? 2'd1 : in_cnt;
	assign accept = s_tvalid && s_tready;

	// token decode at accept
	always_comb begin
		need = rvse_pkg::need_of(in_op);
		uflow = 1'b0;
		nrd_d = '0;
		go_work = 1'b0;
		case (in_op) inside
			[rvse_pkg::OP_ADD:rvse_pkg::OP_CROSS3]: begin
				uflow = cnt_q < CW'(need);
				nrd_d = need - 3'd1;
				go_work = !uflow;
			end
			rvse_pkg::OP_EQUALS: begin
				uflow = cnt_q < CW'(2);
				nrd_d = uflow ? 3'd0 : 3'd1;
				go_work = 1'b1;
			end
			rvse_pkg::OP_END: begin
				uflow = cnt_q < CW'(end_n);
				if (cnt_q == '0)
					nrd_d = '0;
				else if (uflow)
					nrd_d = {1'b0, cnt_q[1:0]} - 3'd1;
				else
					nrd_d = {1'b0, end_n} - 3'd1;
				go_work = 1'b1;
			end
			default: ;
		endcase
	end

	// product term selection
	always_comb begin
		mx = a_q[0];
		my = a_q[1];
		mneg = 1'b0;
		case (op_q)
			rvse_pkg::OP_INTPOW: begin
				mx = pw_q;
				my = a_q[0];
			end
			rvse_pkg::OP_DOT2: begin
				mx = (t_q == 2'd0) ? a_q[0] : a_q[1];
				my = (t_q == 2'd0) ? a_q[2] : a_q[3];
			end
			rvse_pkg::OP_DOT3: begin
				case (t_q)
					2'd0: begin mx = a_q[0]; my = a_q[3]; end
					2'd1: begin mx = a_q[1]; my = a_q[4]; end
					default: begin mx = a_q[2]; my = a_q[5]; end
				endcase
			end
			rvse_pkg::OP_SCALE2, rvse_pkg::OP_SCALE3: begin
				case (j_q)
					2'd0: my = a_q[1];
					2'd1: my = a_q[2];
					default: my = a_q[3];
				endcase
			end
			rvse_pkg::OP_CROSS3: begin
				mneg = t_q[0];
				case ({j_q, t_q[0]})
					3'b000: begin mx = a_q[1]; my = a_q[5]; end
					3'b001: begin mx = a_q[2]; my = a_q[4]; end
					3'b010: begin mx = a_q[2]; my = a_q[3]; end
					3'b011: begin mx = a_q[0]; my = a_q[5]; end
					3'b100: begin mx = a_q[0]; my = a_q[4]; end
					default: begin mx = a_q[1]; my = a_q[3]; end
				endcase
			end
			default: ;
		endcase
		mprod = mx * my;
	end

	assign rnd = rvse_pkg::sat66((acc_q + HALF) >>> FRACTION_BITS);

	always_comb begin
		case (em_q)
			2'd0: emit_val = eq_ok_q || op_q == rvse_pkg::OP_END ? a_q[0] : '0;
			2'd1: emit_val = a_q[1];
			default: emit_val = a_q[2];
		endcase
		if (op_q == rvse_pkg::OP_EQUALS)
			emit_val = eq_ok_q ? rvse_pkg::sat_addsub(a_q[1], a_q[0], 1'b1) : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rvse_pkg::ST_IDLE:
				if (accept && go_work)
					state_d = (nrd_d == '0) ? rvse_pkg::ST_EXEC : rvse_pkg::ST_READ;
			rvse_pkg::ST_READ:
				if (rd_q == nrd_q)
					state_d = rvse_pkg::ST_LAST;
			rvse_pkg::ST_LAST:
				state_d = rvse_pkg::ST_EXEC;
			rvse_pkg::ST_EXEC:
				case (op_q)
					rvse_pkg::OP_MUL, rvse_pkg::OP_DOT2, rvse_pkg::OP_DOT3,
					rvse_pkg::OP_SCALE2, rvse_pkg::OP_SCALE3, rvse_pkg::OP_CROSS3:
						state_d = rvse_pkg::ST_MUL;
					rvse_pkg::OP_INTPOW:
						state_d = (pexp_q == '0) ? rvse_pkg::ST_WB : rvse_pkg::ST_MUL;
					rvse_pkg::OP_DIV:
						state_d = (a_q[1] == '0) ? rvse_pkg::ST_WB : rvse_pkg::ST_DIV;
					rvse_pkg::OP_EQUALS, rvse_pkg::OP_END:
						state_d = rvse_pkg::ST_EMIT;
					default:
						state_d = rvse_pkg::ST_WB;
				endcase
			rvse_pkg::ST_MUL:
				state_d = rvse_pkg::ST_ADD;
			rvse_pkg::ST_ADD:
				if (op_q != rvse_pkg::OP_INTPOW && t_q != rvse_pkg::terms_of(op_q) - 2'd1)
					state_d = rvse_pkg::ST_MUL;
				else
					state_d = rvse_pkg::ST_RND;
			rvse_pkg::ST_RND:
				if (op_q == rvse_pkg::OP_INTPOW)
					state_d = (pe_q == 15'd1) ? rvse_pkg::ST_WB : rvse_pkg::ST_MUL;
				else
					state_d = (j_q == m_q - 2'd1) ? rvse_pkg::ST_WB : rvse_pkg::ST_MUL;
			rvse_pkg::ST_DIV:
				if (div_done)
					state_d = rvse_pkg::ST_WB;
			rvse_pkg::ST_WB:
				if (wb_q >= m_q - 2'd1)
					state_d = rvse_pkg::ST_IDLE;
			rvse_pkg::ST_EMIT:
				if (emit_load && em_q == nem_q - 2'd1)
					state_d = rvse_pkg::ST_IDLE;
			default:
				state_d = rvse_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = state_q == rvse_pkg::ST_IDLE;
		div_start = state_q == rvse_pkg::ST_EXEC && op_q == rvse_pkg::OP_DIV &&
			a_q[1] != '0;
		emit_load = state_q == rvse_pkg::ST_EMIT && (!out_valid_q || m_tready);
		ram_raddr = AW'(cnt_q - CW'(1) - CW'(rd_q));
		ram_we = 1'b0;
		ram_waddr = AW'(cnt_q - CW'(1));
		ram_wdata = top_q;
		if (state_q == rvse_pkg::ST_IDLE) begin
			ram_we = accept && in_op == rvse_pkg::OP_PUSH && cnt_q != '0 &&
				cnt_q < CW'(STACK_DEPTH);
		end else if (state_q == rvse_pkg::ST_WB) begin
			ram_we = wb_q < m_q;
			ram_waddr = AW'(nc_q - CW'(1) - CW'(wb_q));
			ram_wdata = (wb_q == 2'd1) ? r_q[1] : r_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvse_pkg::ST_IDLE;
			cnt_q <= '0;
			top_q <= '0;
			err_q <= rvse_pkg::STAT_OK;
			out_valid_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_pend_s1 <= state_q == rvse_pkg::ST_READ;
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				rvse_pkg::ST_IDLE:
					if (accept) begin
						if (in_op == rvse_pkg::OP_PUSH) begin
							if (cnt_q >= CW'(STACK_DEPTH)) begin
								if (err_q == rvse_pkg::STAT_OK)
									err_q <= rvse_pkg::STAT_OVF;
							end else begin
								top_q <= in_val;
								cnt_q <= cnt_q + CW'(1);
							end
						end else if (uflow && err_q == rvse_pkg::STAT_OK) begin
							err_q <= rvse_pkg::STAT_UNF;
						end
					end
				rvse_pkg::ST_EXEC:
					if (op_q == rvse_pkg::OP_DIV && a_q[1] == '0 &&
							err_q == rvse_pkg::STAT_OK)
						err_q <= rvse_pkg::STAT_DIVZ;
				rvse_pkg::ST_WB:
					if (wb_q >= m_q - 2'd1) begin
						top_q <= r_q[0];
						cnt_q <= nc_q;
					end
				rvse_pkg::ST_EMIT:
					if (emit_load && em_q == nem_q - 2'd1) begin
						cnt_q <= '0;
						top_q <= '0;
						err_q <= rvse_pkg::STAT_OK;
					end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (rd_pend_s1)
			a_q[rd_dep_s1] <= ram_rdata;
		rd_dep_s1 <= rd_q;
		case (state_q)
			rvse_pkg::ST_IDLE:
				if (accept) begin
					op_q <= in_op;
					pexp_q <= in_exp;
					a_q[0] <= top_q;
					a_q[1] <= '0;
					a_q[2] <= '0;
					a_q[3] <= '0;
					a_q[4] <= '0;
					a_q[5] <= '0;
					rd_q <= 3'd1;
					nrd_q <= nrd_d;
					m_q <= rvse_pkg::res_of(in_op);
					nc_q <= cnt_q - CW'(need) + CW'(rvse_pkg::res_of(in_op));
					eq_ok_q <= cnt_q >= CW'(2);
					nem_q <= (in_op == rvse_pkg::OP_END) ? end_n : 2'd1;
				end
			rvse_pkg::ST_READ:
				rd_q <= rd_q + 3'd1;
			rvse_pkg::ST_EXEC: begin
				j_q <= '0;
				t_q <= '0;
				wb_q <= 2'd1;
				em_q <= '0;
				acc_q <= '0;
				pw_q <= ONE;
				pe_q <= pexp_q;
				case (op_q)
					rvse_pkg::OP_ADD, rvse_pkg::OP_SUB:
						r_q[0] <= rvse_pkg::sat_addsub(a_q[1], a_q[0],
							op_q == rvse_pkg::OP_SUB);
					rvse_pkg::OP_ADD2, rvse_pkg::OP_SUB2: begin
						r_q[0] <= rvse_pkg::sat_addsub(a_q[2], a_q[0],
							op_q == rvse_pkg::OP_SUB2);
						r_q[1] <= rvse_pkg::sat_addsub(a_q[3], a_q[1],
							op_q == rvse_pkg::OP_SUB2);
					end
					rvse_pkg::OP_ADD3, rvse_pkg::OP_SUB3: begin
						r_q[0] <= rvse_pkg::sat_addsub(a_q[3], a_q[0],
							op_q == rvse_pkg::OP_SUB3);
						r_q[1] <= rvse_pkg::sat_addsub(a_q[4], a_q[1],
							op_q == rvse_pkg::OP_SUB3);
						r_q[2] <= rvse_pkg::sat_addsub(a_q[5], a_q[2],
							op_q == rvse_pkg::OP_SUB3);
					end
					rvse_pkg::OP_INTPOW:
						r_q[0] <= ONE;
					rvse_pkg::OP_DIV:
						r_q[0] <= a_q[0][31] ? rvse_pkg::Q_MIN : rvse_pkg::Q_MAX;
					default: ;
				endcase
			end
			rvse_pkg::ST_MUL:
				prod_s1 <= mneg ? -mprod : mprod;
			rvse_pkg::ST_ADD: begin
				acc_q <= acc_q + 66'(prod_s1);
				t_q <= t_q + 2'd1;
			end
			rvse_pkg::ST_RND: begin
				acc_q <= '0;
				t_q <= '0;
				if (op_q == rvse_pkg::OP_INTPOW) begin
					pw_q <= rnd;
					pe_q <= pe_q - 15'd1;
					r_q[0] <= rnd;
				end else begin
					r_q[j_q] <= rnd;
					j_q <= j_q + 2'd1;
				end
			end
			rvse_pkg::ST_DIV:
				if (div_done)
					r_q[0] <= div_quo;
			rvse_pkg::ST_WB:
				wb_q <= wb_q + 2'd1;
			rvse_pkg::ST_EMIT:
				if (emit_load)
					em_q <= em_q + 2'd1;
			default: ;
		endcase
		if (emit_load) begin
			out_data_q <= emit_val;
			out_last_q <= em_q == nem_q - 2'd1;
			out_stat_q <= err_q;
		end
	end

	rvse_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rvse_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (a_q[0]),
		.den   (a_q[1]),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_stat_q;

endmodule

[src/rvse_checker.sv]
module rvse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [4:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
			$stable(m_tuser))
		else $error("output word changed while stalled");

	// a push never starts an output word
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == rvse_pkg::OP_PUSH |=>
			!m_tvalid || $past(m_tvalid && !m_tready))
		else $error("push produced an output word");

	// unused opcodes are dropped silently
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser > rvse_pkg::OP_END |=>
			!m_tvalid || $past(m_tvalid && !m_tready))
		else $error("unused opcode produced an output word");

endmodule

bind rpn_vector_stack_evaluator_unit rvse_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
